### hw/rtl/rrts_pkg.sv
// Shared types and constants of the round-robin thread scheduler.
// Used by the scheduler core, its thread table and its checker; depends on nothing.

package rrts_pkg;

  localparam int ID_W            = 4;
  localparam int PRIO_W          = 8;
  localparam int MAX_THREADS_DEF = 16;
  localparam logic [PRIO_W-1:0] MAIN_PRIO_RST = 8'd31;

  // Highest ready count the 4-bit thread id space allows.
  localparam logic [4:0] MAX_IDS = 5'd16;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    REQ_CREATE,
    REQ_SCHEDULE,
    REQ_BLOCK,
    REQ_UNBLOCK
  } req_t;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_IN_USE,
    ERR_EMPTY,
    ERR_NOT_WAITING
  } err_code_t;

  typedef enum logic [2:0] {
    ST_UNUSED,
    ST_RUNNING,
    ST_READY,
    ST_BLOCKED,
    ST_WAITING,
    ST_HANGING
  } thread_st_t;

  typedef struct packed {
    thread_st_t        st;
    logic [PRIO_W-1:0] prio;
  } tbl_entry_t;

  typedef struct packed {
    logic       en;
    tbl_entry_t data;
  } tbl_wr_t;

  // Input word, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]        pad;
    logic [1:0]        block_kind;
    logic [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]   thread_id;
  } in_word_t;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic [3:0]        pad;
    logic [4:0]        ready_count;
    err_code_t         error_code;
    logic [PRIO_W-1:0] slice_ticks;
    logic              switched;
    logic [ID_W-1:0]   current_thread;
  } out_word_t;

endpackage

### hw/rtl/round_robin_thread_scheduler_core.sv
// Top level of the round-robin thread scheduler: request sequencer, ready ring memory
// and result register. Depends on rrts_pkg and rrts_table.

// The scheduler keeps a ready deque of thread ids in a ring memory, a state and
// priority entry for each thread in a table memory, and the id of the running thread.
// Each request word (create, schedule, block current, unblock) yields exactly one
// result word carrying the running thread, whether a switch happened, its time slice
// (equal to its priority), an error code and the ready count. A request that fails its
// check changes no state. Create, unblock and every failing request pass through the
// accept step, in which the table and ring are read, and one execute step, in which
// the entry is checked and, if it passes, modified and written back. A schedule or
// block that picks a thread adds a switch step, because the picked thread's table
// entry can only be read after the ring has named it, the thread table read being
// registered. One request is in flight at a time. A finished result sits in an output
// register, so the next request is taken while it waits; the step that writes the
// result holds until that register is free. Thread zero runs after reset with the
// priority in main_priority, and a write of that register takes effect for thread zero
// at once. Write configuration only while no request is in flight.

module round_robin_thread_scheduler_core #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // thread_id[3:0], priority_req[11:4], block_kind[13:12], zero fill.
  input  logic [rrts_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0].
  input  logic [rrts_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // current_thread[3:0], switched[4], slice_ticks[12:5], error_code[14:13],
  // ready_count[19:15], zero fill.
  output logic [rrts_pkg::OUT_TDATA_W-1:0] out_tdata,
  // main_priority register.
  input  logic                             cfg_wr_en,
  input  logic [rrts_pkg::PRIO_W-1:0]      cfg_wr_data
);
  import rrts_pkg::*;

  localparam int IDX_W = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_THREADS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_THREADS);
  localparam logic [CNT_W:0]   SUM_MAX  = (CNT_W + 1)'(MAX_THREADS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWITCH
  } state_t;

  function automatic logic [IDX_W-1:0] to_idx(logic [ID_W-1:0] v);
    logic [IDX_W+ID_W-1:0] w;
    w = {{IDX_W{1'b0}}, v};
    return w[IDX_W-1:0];
  endfunction

  function automatic out_word_t pack_res(logic [ID_W-1:0] cur, logic sw,
                                         logic [PRIO_W-1:0] slice, err_code_t err,
                                         logic [CNT_W-1:0] cnt);
    out_word_t        w;
    logic [CNT_W+4:0] c;
    c                = {5'd0, cnt};
    w.pad            = '0;
    w.ready_count    = c[4:0];
    w.error_code     = err;
    w.slice_ticks    = slice;
    w.switched       = sw;
    w.current_thread = cur;
    return w;
  endfunction

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [PRIO_W-1:0] prio_req_r, prio_req_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [PRIO_W-1:0] main_prio_r, main_prio_nxt;
  logic [ID_W-1:0]   cur_r, cur_nxt;
  logic [PRIO_W-1:0] cur_prio_r, cur_prio_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              fwd_r, fwd_nxt;
  logic [PRIO_W-1:0] held_prio_r, held_prio_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  // Ready ring memory.
  logic [ID_W-1:0]   ring_mem_r [MAX_THREADS];
  logic [ID_W-1:0]   ring_q_r;
  logic              ring_rd_en;
  logic              ring_we;
  logic [IDX_W-1:0]  ring_waddr;
  logic [ID_W-1:0]   ring_wdata;

  // Thread table port.
  logic              tbl_rd_en;
  logic [IDX_W-1:0]  tbl_rd_addr;
  tbl_entry_t        tbl_rd_ent;
  tbl_wr_t           tbl_wr;
  logic [IDX_W-1:0]  tbl_wr_addr;

  in_word_t          in_word;
  logic              out_free;
  logic [CNT_W:0]    tail_sum;
  logic [CNT_W:0]    tail_wrap;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  head_dec;
  logic              ring_full;
  logic [PRIO_W-1:0] cur_slice;
  logic              id_ok;
  logic              requeue;
  logic [ID_W-1:0]   new_id;
  thread_st_t        blk_st;
  logic [PRIO_W-1:0] sw_prio;

  rrts_table #(
    .MAX_THREADS (MAX_THREADS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_ent  (tbl_rd_ent),
    .wr      (tbl_wr),
    .wr_addr (tbl_wr_addr)
  );

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem_r[ring_waddr] <= ring_wdata;
    end
    if (ring_rd_en) begin
      ring_q_r <= ring_mem_r[head_r];
    end
  end

  assign in_word    = in_word_t'(in_tdata);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_free   = !out_valid_r || out_tready;

  // Ring pointer arithmetic; the depth need not be a power of two.
  assign tail_sum  = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(count_r);
  assign tail_wrap = (tail_sum >= SUM_MAX) ? (tail_sum - SUM_MAX) : tail_sum;
  assign tail_idx  = tail_wrap[IDX_W-1:0];
  assign head_inc  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign head_dec  = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign ring_full = (count_r == CNT_FULL);

  // Thread zero always runs at the configured main priority.
  assign cur_slice = (cur_r == '0) ? main_prio_r : cur_prio_r;
  assign id_ok     = int'(id_r) < MAX_THREADS;

  // Only a schedule puts the running thread back; a block has just parked it.
  assign requeue = (req_r == REQ_SCHEDULE) && (tbl_rd_ent.st == ST_RUNNING);
  // With an empty ring the re-queued thread is the one popped again.
  assign new_id  = (count_r == '0) ? cur_r : ring_q_r;
  assign sw_prio = fwd_r ? held_prio_r : tbl_rd_ent.prio;

  always_comb begin
    case (kind_r)
      2'd0:    blk_st = ST_BLOCKED;
      2'd1:    blk_st = ST_WAITING;
      default: blk_st = ST_HANGING;
    endcase
  end

  always_comb begin
    err_code_t        err;
    logic [CNT_W-1:0] cnt;
    logic             pushed;

    err    = ERR_OK;
    cnt    = count_r;
    pushed = 1'b0;

    state_nxt     = state_r;
    req_nxt       = req_r;
    id_nxt        = id_r;
    prio_req_nxt  = prio_req_r;
    kind_nxt      = kind_r;
    main_prio_nxt = main_prio_r;
    cur_nxt       = cur_r;
    cur_prio_nxt  = cur_prio_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    fwd_nxt       = fwd_r;
    held_prio_nxt = held_prio_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    tbl_rd_en   = 1'b0;
    tbl_rd_addr = to_idx(cur_r);
    tbl_wr      = '0;
    tbl_wr_addr = to_idx(cur_r);
    ring_rd_en  = 1'b0;
    ring_we     = 1'b0;
    ring_waddr  = tail_idx;
    ring_wdata  = cur_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_wr_en) begin
      main_prio_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt      = req_t'(in_tuser);
          id_nxt       = in_word.thread_id;
          prio_req_nxt = in_word.priority_req;
          kind_nxt     = in_word.block_kind;
          tbl_rd_en    = 1'b1;
          if (req_t'(in_tuser) inside {REQ_CREATE, REQ_UNBLOCK}) begin
            tbl_rd_addr = to_idx(in_word.thread_id);
          end
          ring_rd_en = 1'b1;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        case (req_r)
          REQ_CREATE: begin
            if (out_free) begin
              if (!id_ok || tbl_rd_ent.st != ST_UNUSED) begin
                err = ERR_IN_USE;
              end else begin
                tbl_wr.en        = 1'b1;
                tbl_wr.data.st   = ST_READY;
                tbl_wr.data.prio = prio_req_r;
                tbl_wr_addr      = to_idx(id_r);
                if (!ring_full) begin
                  ring_we    = 1'b1;
                  ring_waddr = tail_idx;
                  ring_wdata = id_r;
                  cnt        = count_r + 1'b1;
                end
              end
              count_nxt     = cnt;
              out_valid_nxt = 1'b1;
              out_word_nxt  = pack_res(cur_r, 1'b0, cur_slice, err, cnt);
              state_nxt     = S_IDLE;
            end
          end

          REQ_UNBLOCK: begin
            if (out_free) begin
              if (!id_ok || !(tbl_rd_ent.st inside {[ST_BLOCKED:ST_HANGING]})) begin
                err = ERR_NOT_WAITING;
              end else begin
                tbl_wr.en        = 1'b1;
                tbl_wr.data.st   = ST_READY;
                tbl_wr.data.prio = tbl_rd_ent.prio;
                tbl_wr_addr      = to_idx(id_r);
                if (!ring_full) begin
                  ring_we    = 1'b1;
                  ring_waddr = head_dec;
                  ring_wdata = id_r;
                  head_nxt   = head_dec;
                  cnt        = count_r + 1'b1;
                end
              end
              count_nxt     = cnt;
              out_valid_nxt = 1'b1;
              out_word_nxt  = pack_res(cur_r, 1'b0, cur_slice, err, cnt);
              state_nxt     = S_IDLE;
            end
          end

          default: begin
            // Schedule or block current.
            if ((count_r == '0) && !requeue) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_word_nxt  = pack_res(cur_r, 1'b0, cur_slice, ERR_EMPTY, count_r);
                state_nxt     = S_IDLE;
              end
            end else begin
              // Write back the outgoing thread, then pop the head.
              tbl_wr.data.prio = tbl_rd_ent.prio;
              tbl_wr_addr      = to_idx(cur_r);
              if (req_r == REQ_BLOCK) begin
                tbl_wr.en      = 1'b1;
                tbl_wr.data.st = blk_st;
              end else if (requeue) begin
                tbl_wr.en      = 1'b1;
                tbl_wr.data.st = ST_READY;
                if (!ring_full) begin
                  ring_we    = 1'b1;
                  ring_waddr = tail_idx;
                  ring_wdata = cur_r;
                  pushed     = 1'b1;
                end
              end
              count_nxt     = pushed ? count_r : count_r - 1'b1;
              head_nxt      = head_inc;
              cur_nxt       = new_id;
              // Picking the same thread again reads the entry being written now.
              fwd_nxt       = (new_id == cur_r);
              held_prio_nxt = tbl_rd_ent.prio;
              tbl_rd_en     = 1'b1;
              tbl_rd_addr   = to_idx(new_id);
              state_nxt     = S_SWITCH;
            end
          end
        endcase
      end

      S_SWITCH: begin
        if (out_free) begin
          tbl_wr.en        = 1'b1;
          tbl_wr.data.st   = ST_RUNNING;
          tbl_wr.data.prio = sw_prio;
          tbl_wr_addr      = to_idx(cur_r);
          cur_prio_nxt     = sw_prio;
          out_valid_nxt    = 1'b1;
          out_word_nxt     = pack_res(cur_r, 1'b1,
                                      (cur_r == '0) ? main_prio_r : sw_prio,
                                      ERR_OK, count_r);
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      main_prio_r <= MAIN_PRIO_RST;
      cur_r       <= '0;
      cur_prio_r  <= '0;
      head_r      <= '0;
      count_r     <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      main_prio_r <= main_prio_nxt;
      cur_r       <= cur_nxt;
      cur_prio_r  <= cur_prio_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    id_r        <= id_nxt;
    prio_req_r  <= prio_req_nxt;
    kind_r      <= kind_nxt;
    held_prio_r <= held_prio_nxt;
    out_word_r  <= out_word_nxt;
  end

endmodule

### hw/rtl/rrts_table.sv
// Per-thread state and priority table: one synchronous memory with a registered read.
// Depends on rrts_pkg; entries never written read back as their reset value.

module rrts_table #(
  parameter int   MAX_THREADS = rrts_pkg::MAX_THREADS_DEF,
  localparam int  IDX_W       = $clog2(MAX_THREADS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output rrts_pkg::tbl_entry_t rd_ent,
  input  rrts_pkg::tbl_wr_t    wr,
  input  logic [IDX_W-1:0]     wr_addr
);
  import rrts_pkg::*;

  tbl_entry_t             tbl_mem_r [MAX_THREADS];
  tbl_entry_t             rd_data_r;
  logic [MAX_THREADS-1:0] vld_r;
  logic                   rd_vld_r;
  logic                   rd_zero_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tbl_mem_r[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= tbl_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_zero_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= vld_r[rd_addr];
        rd_zero_r <= (rd_addr == '0);
      end
    end
  end

  // Thread zero comes out of reset running; every other id starts unused.
  always_comb begin
    if (rd_vld_r) begin
      rd_ent = rd_data_r;
    end else begin
      rd_ent.st   = rd_zero_r ? ST_RUNNING : ST_UNUSED;
      rd_ent.prio = '0;
    end
  end

endmodule

### hw/rtl/rrts_chk.sv
// Port-level checker for the round-robin thread scheduler, bound to its top level.
// Depends on rrts_pkg and round_robin_thread_scheduler_core.

module rrts_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rrts_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rrts_pkg::*;

  out_word_t ow;
  assign ow = out_word_t'(out_tdata);

  // A result that reports a switch never carries an error.
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ow.switched |-> ow.error_code == ERR_OK)
    else $error("switch reported together with an error code");

  // An empty-queue error can only be given while the ready deque is empty.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ow.error_code == ERR_EMPTY |-> ow.ready_count == 5'd0)
    else $error("empty-queue error with a nonzero ready count");

  // The ready count never exceeds the thread id space; each id sits in the deque at most once.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ow.ready_count <= MAX_IDS)
    else $error("ready count beyond the thread id space");

  // Requests are handled one at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed or dropped");

endmodule

bind round_robin_thread_scheduler_core rrts_chk u_rrts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
